### design/modinv_pkg.sv
package modinv_pkg;

  // Modulus loaded at reset
  localparam logic [63:0] RESET_MODULUS = 64'd998244353;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // take a new request, seed the Euclid registers
    logic div_init;  // start a quotient/remainder pass
    logic div_step;  // one restoring-division bit
    logic update;    // rotate remainders and coefficients
    logic finish;    // capture result into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic m_one;     // modulus is one
    logic a_le1;     // remainder_a <= 1, loop done
    logic b_zero;    // divisor is zero, loop ends
    logic div_last;  // final division bit this cycle
  } status_t;

endpackage

### design/modinv_ctrl.sv
module modinv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  modinv_pkg::status_t status,
  output modinv_pkg::cmd_t    cmd
);
  import modinv_pkg::*;

  state_t state;
  state_t state_next;

  // State register and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall = (state != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.m_one || status.a_le1 || status.b_zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_CHECK;
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // An accepted request always goes to the loop test
  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_CHECK))
    else $error("accepted request did not enter loop test");

  // Division pass ends in a coefficient update
  a_div_to_update: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && status.div_last) |=> (state == ST_UPDATE))
    else $error("division pass did not end in update");

  // A result is never written over a pending one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.finish)
    else $error("result written while output still stalled");
`endif

endmodule

### design/modinv_dpath.sv
module modinv_dpath #(
  parameter int WIDTH = 30
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                modulus_wr_en,
  input  logic [WIDTH-1:0]    modulus_wr_data,
  input  logic [WIDTH-1:0]    value,
  input  modinv_pkg::cmd_t    cmd,
  output modinv_pkg::status_t status,
  output logic [WIDTH-1:0]    inverse,
  output logic                no_inverse
);
  import modinv_pkg::*;

  // Coefficients stay within the modulus in magnitude; the product
  // accumulator within twice that, so three guard bits cover all.
  localparam int CW = WIDTH + 3;
  localparam int CNTW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CNTW-1:0] LAST_BIT = CNTW'(WIDTH - 1);

  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] remainder_a;
  logic [WIDTH-1:0] remainder_b;
  logic [CW-1:0]    coeff_x;
  logic [CW-1:0]    coeff_y;
  logic [WIDTH-1:0] rem;      // partial remainder
  logic [WIDTH-1:0] dq;       // dividend shifting out, quotient shifting in
  logic [CW-1:0]    prod;     // running quotient * coeff_y
  logic [CNTW-1:0]  cnt;

  logic [WIDTH:0]   rem_shift;
  logic             q_bit;
  logic [WIDTH:0]   rem_sub;
  logic [CW-1:0]    prod_next;
  logic [CW-1:0]    fold;

  // Modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= RESET_MODULUS[WIDTH-1:0];
    end else if (modulus_wr_en) begin
      modulus <= modulus_wr_data;
    end
  end

  // One restoring-division bit, with the quotient times coeff_y built MSB first
  assign rem_shift = {rem, dq[WIDTH-1]};
  assign q_bit     = (rem_shift >= {1'b0, remainder_b});
  assign rem_sub   = rem_shift - {1'b0, remainder_b};
  assign prod_next = {prod[CW-2:0], 1'b0} + (q_bit ? coeff_y : '0);

  // Euclid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      remainder_a <= '0;
      remainder_b <= '0;
      coeff_x     <= '0;
      coeff_y     <= '0;
      rem         <= '0;
      dq          <= '0;
      prod        <= '0;
      cnt         <= '0;
    end else begin
      if (cmd.load) begin
        remainder_a <= value;
        remainder_b <= modulus;
        coeff_x     <= CW'(1);
        coeff_y     <= '0;
      end
      if (cmd.div_init) begin
        rem  <= '0;
        dq   <= remainder_a;
        prod <= '0;
        cnt  <= '0;
      end
      if (cmd.div_step) begin
        rem  <= q_bit ? rem_sub[WIDTH-1:0] : rem_shift[WIDTH-1:0];
        dq   <= {dq[WIDTH-2:0], q_bit};
        prod <= prod_next;
        cnt  <= cnt + CNTW'(1);
      end
      if (cmd.update) begin
        remainder_a <= remainder_b;
        remainder_b <= rem;
        coeff_x     <= coeff_y;
        coeff_y     <= coeff_x - prod;
      end
    end
  end

  // Fold a negative coefficient back into range
  assign fold = coeff_x[CW-1] ? (coeff_x + {3'b000, modulus}) : coeff_x;

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (status.m_one) begin
        inverse    <= '0;
        no_inverse <= 1'b0;
      end else if (!status.a_le1) begin
        inverse    <= '0;
        no_inverse <= 1'b1;
      end else begin
        inverse    <= fold[WIDTH-1:0];
        no_inverse <= 1'b0;
      end
    end
  end

  always_comb begin
    status.m_one    = (modulus == WIDTH'(1));
    status.a_le1    = (remainder_a <= WIDTH'(1));
    status.b_zero   = (remainder_b == '0);
    status.div_last = (cnt == LAST_BIT);
  end

`ifndef ASSERT_OFF
  // Partial remainder always stays below the divisor
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_init || cmd.div_step) |=> (rem < remainder_b))
    else $error("partial remainder not below divisor");

  // Update shifts the remainder pair down by one
  a_update_rotate: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> (remainder_a == $past(remainder_b)) && (coeff_x == $past(coeff_y)))
    else $error("remainder pair not rotated on update");

  // Division never starts on a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init |-> (remainder_b != '0))
    else $error("division started with zero divisor");
`endif

endmodule

### design/modular_inverse_ext_euclid.sv
// Modular inverse by the extended Euclidean algorithm, one request at a time.
// Each Euclid step (about 45 worst case at WIDTH = 30) is a loop test, a bit-serial
// division pass and an update of remainders and coefficients. The next request
// is taken once the result is in the output register. Reset (rst, synchronous)
// clears the sequencer, output valid and Euclid registers and loads the modulus
// 998244353 (low WIDTH bits).
module modular_inverse_ext_euclid #(
  parameter int WIDTH = 30
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             modulus_wr_en,
  input  logic [WIDTH-1:0] modulus_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] inverse,
  output logic             no_inverse
);
  import modinv_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  modinv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Euclid datapath
  modinv_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .modulus_wr_en   (modulus_wr_en),
    .modulus_wr_data (modulus_wr_data),
    .value           (value),
    .cmd             (cmd),
    .status          (status),
    .inverse         (inverse),
    .no_inverse      (no_inverse)
  );

endmodule

### tb/sv/modular_inverse_ext_euclid_test.sv
module modular_inverse_ext_euclid_test;
  timeunit 1ns;
  timeprecision 1ps;

  import modinv_pkg::*;

  localparam int W = 30;
  localparam logic [W-1:0] FULL_MASK = {W{1'b1}};
  localparam int DIRECTED_COUNT = 27;
  localparam int SEGMENTS_PER_PHASE = 4;
  localparam int ITEMS_PER_SEGMENT = 33;

  // One expected inverse
  typedef struct packed {
    logic [W-1:0] inverse;
    logic         no_inverse;
  } inv_result_t;

  // Directed stimulus row: either a modulus write or a value to invert
  typedef enum logic {
    ROW_VALUE,
    ROW_MODULUS
  } row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [W-1:0] data;
    logic         fixed_result;
    logic [W-1:0] exp_inverse;
    logic         exp_no_inverse;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         modulus_wr_en = 1'b0;
  logic [W-1:0] modulus_wr_data = '0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [W-1:0] value = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [W-1:0] inverse;
  logic         no_inverse;

  inv_result_t  pending_inverses[$];
  logic [W-1:0] modulus_setting = W'(RESET_MODULUS);
  int unsigned  send_idle_pct = 19;
  int unsigned  recv_idle_pct = 49;
  int           error_count = 0;
  int           request_count = 0;
  int           checked_count = 0;
  int           modulus_writes = 0;
  int           no_inverse_count = 0;

  modular_inverse_ext_euclid #(
    .WIDTH(W)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .modulus_wr_en  (modulus_wr_en),
    .modulus_wr_data(modulus_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .value          (value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .inverse        (inverse),
    .no_inverse     (no_inverse)
  );

  always #1 clk = ~clk;

  // Extended Euclid with 64-bit two's complement coefficients
  function automatic inv_result_t predict_inverse(input logic [W-1:0] m,
                                                  input logic [W-1:0] v);
    logic [63:0] rem_a;
    logic [63:0] rem_b;
    logic [63:0] cx;
    logic [63:0] cy;
    logic [63:0] quo;
    logic [63:0] tmp;
    inv_result_t r;
    r.inverse = '0;
    r.no_inverse = 1'b0;
    if (m == 1) return r;
    rem_a = 64'(v);
    rem_b = 64'(m);
    cx = 64'd1;
    cy = 64'd0;
    while (rem_a > 1) begin
      // divisor hit zero with remainder above one: shared factor
      if (rem_b == 0) begin
        r.no_inverse = 1'b1;
        return r;
      end
      quo = rem_a / rem_b;
      tmp = rem_b;
      rem_b = rem_a % rem_b;
      rem_a = tmp;
      tmp = cy;
      cy = cx - quo * cy;
      cx = tmp;
    end
    // fold a negative coefficient back into range
    if (cx[63]) cx = cx + 64'(m);
    r.inverse = cx[W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Offer one request, with random idle cycles ahead of it
  task automatic send_value(input logic [W-1:0] v, input inv_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      value <= W'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_inverses = {pending_inverses, want};
    request_count++;
    @(negedge clk);
  endtask

  // Modulus changes only once every request has come back
  task automatic write_modulus(input logic [W-1:0] m);
    in_valid <= 1'b0;
    while (pending_inverses.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    modulus_wr_en <= 1'b1;
    modulus_wr_data <= m;
    @(negedge clk);
    modulus_wr_en <= 1'b0;
    modulus_wr_data <= W'($urandom);
    modulus_setting = m;
    modulus_writes++;
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    inv_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_inverses.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: inverse=%0d no_inverse=%0b",
                                  inverse, no_inverse));
      end else begin
        want = pending_inverses.pop_front();
        if (inverse !== want.inverse)
          report_mismatch($sformatf("inverse got %0d want %0d", inverse, want.inverse));
        if (no_inverse !== want.no_inverse)
          report_mismatch($sformatf("no_inverse got %0b want %0b", no_inverse,
                                    want.no_inverse));
        if (want.no_inverse) no_inverse_count++;
        checked_count++;
      end
    end
  end

  // Hard limit on run length
  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_inverses.size());
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    row_t         directed_rows [DIRECTED_COUNT];
    inv_result_t  want;
    logic [W-1:0] m;
    logic [W-1:0] v;

    directed_rows = '{
      // reset modulus 998244353
      '{ROW_VALUE,   30'd0,          1'b1, 30'd1,         1'b0},
      '{ROW_VALUE,   30'd1,          1'b1, 30'd1,         1'b0},
      '{ROW_VALUE,   30'd2,          1'b1, 30'd499122177, 1'b0},
      '{ROW_VALUE,   30'd998244352,  1'b1, 30'd998244352, 1'b0},
      '{ROW_VALUE,   30'd998244353,  1'b1, 30'd0,         1'b1},
      '{ROW_VALUE,   30'd1073741823, 1'b0, 30'd0,         1'b0},
      '{ROW_VALUE,   30'd12345,      1'b0, 30'd0,         1'b0},
      // modulus one: always zero
      '{ROW_MODULUS, 30'd1,          1'b0, 30'd0,         1'b0},
      '{ROW_VALUE,   30'd0,          1'b1, 30'd0,         1'b0},
      '{ROW_VALUE,   30'd1073741823, 1'b1, 30'd0,         1'b0},
      // modulus zero: zero and one still skip the loop
      '{ROW_MODULUS, 30'd0,          1'b0, 30'd0,         1'b0},
      '{ROW_VALUE,   30'd0,          1'b1, 30'd1,         1'b0},
      '{ROW_VALUE,   30'd1,          1'b1, 30'd1,         1'b0},
      '{ROW_VALUE,   30'd7,          1'b1, 30'd0,         1'b1},
      // largest modulus, composite
      '{ROW_MODULUS, 30'd1073741823, 1'b0, 30'd0,         1'b0},
      '{ROW_VALUE,   30'd3,          1'b1, 30'd0,         1'b1},
      '{ROW_VALUE,   30'd2,          1'b1, 30'd536870912, 1'b0},
      '{ROW_VALUE,   30'd1073741823, 1'b1, 30'd0,         1'b1},
      '{ROW_VALUE,   30'd536870912,  1'b0, 30'd0,         1'b0},
      // modulus two
      '{ROW_MODULUS, 30'd2,          1'b0, 30'd0,         1'b0},
      '{ROW_VALUE,   30'd1,          1'b1, 30'd1,         1'b0},
      '{ROW_VALUE,   30'd2,          1'b1, 30'd0,         1'b1},
      '{ROW_VALUE,   30'd3,          1'b0, 30'd0,         1'b0},
      // small composite modulus
      '{ROW_MODULUS, 30'd12,         1'b0, 30'd0,         1'b0},
      '{ROW_VALUE,   30'd5,          1'b0, 30'd0,         1'b0},
      '{ROW_VALUE,   30'd6,          1'b1, 30'd0,         1'b1},
      '{ROW_VALUE,   30'd1073741823, 1'b0, 30'd0,         1'b0}
    };

    // reset
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      if (directed_rows[i].kind == ROW_MODULUS) begin
        write_modulus(directed_rows[i].data);
      end else begin
        if (directed_rows[i].fixed_result) begin
          want.inverse = directed_rows[i].exp_inverse;
          want.no_inverse = directed_rows[i].exp_no_inverse;
        end else begin
          want = predict_inverse(modulus_setting, directed_rows[i].data);
        end
        send_value(directed_rows[i].data, want);
      end
    end

    // random part, three idle mixes
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEGMENTS_PER_PHASE; seg++) begin
        case ($urandom_range(7))
          0: m = W'(RESET_MODULUS);
          1: m = 30'd1000000007;
          2: m = FULL_MASK;
          3: m = W'($urandom);
          4: m = W'($urandom_range(1000, 2));
          5: m = W'(1) << $urandom_range(29, 1);
          6: m = 30'd1;
          default: m = W'($urandom) | W'(1);
        endcase
        write_modulus(m);
        for (int k = 0; k < ITEMS_PER_SEGMENT; k++) begin
          case ($urandom_range(3))
            0, 1: v = W'($urandom);
            2: v = (m == 0) ? W'($urandom) : W'($urandom % 32'(m));
            default: v = W'($urandom_range(64));
          endcase
          send_value(v, predict_inverse(m, v));
        end
      end
    end

    // drain
    in_valid <= 1'b0;
    while (pending_inverses.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("%0d requests (%0d directed rows), %0d modulus writes, three idle mixes",
             request_count, DIRECTED_COUNT, modulus_writes);
    $display("%0d results checked, %0d without inverse, %0d mismatches",
             checked_count, no_inverse_count, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
